>>> sv/arpc_pkg.sv
`default_nettype none

package arpc_pkg;

  // field widths
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned HDR_W   = 16;
  localparam int unsigned IP_W    = 32;
  localparam int unsigned MAC_W   = 48;
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned CFG_W   = 48;

  localparam int unsigned CACHE_ENTRIES_DEFAULT = 16;

  // arp header checks
  localparam logic [HDR_W-1:0]   MIN_ARP_LEN  = 16'd28;
  localparam logic [HDR_W-1:0]   HTYPE_ETH    = 16'h0001;
  localparam logic [HDR_W-1:0]   PTYPE_IPV4   = 16'h0800;
  localparam logic [HDR_W-1:0]   OPER_REQUEST = 16'h0001;
  localparam logic [STAMP_W-1:0] STAMP_MAX    = 32'hFFFF_FFFF;

  typedef enum logic [CMD_W-1:0] {
    CMD_PACKET  = 2'd0,
    CMD_LEARN   = 2'd1,
    CMD_RESOLVE = 2'd2,
    CMD_TICK    = 2'd3
  } cmd_t;

  typedef enum logic [0:0] {
    CFG_OWN_IP  = 1'b0,
    CFG_OWN_MAC = 1'b1
  } cfg_reg_t;

  // one table entry
  typedef struct packed {
    logic [IP_W-1:0]    ip;
    logic [MAC_W-1:0]   mac;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  // one result item
  typedef struct packed {
    logic             packet_accepted;
    logic             resolve_hit;
    logic [MAC_W-1:0] resolved_mac;
    logic             send_reply;
    logic [MAC_W-1:0] reply_dest_mac;
    logic [IP_W-1:0]  reply_dest_ip;
  } result_t;

endpackage

`default_nettype wire

>>> sv/arpc_cmd_if.sv
`default_nettype none

interface arpc_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [arpc_pkg::CMD_W-1:0]  command;
  logic [arpc_pkg::HDR_W-1:0]  frame_length;
  logic [arpc_pkg::HDR_W-1:0]  hardware_type;
  logic [arpc_pkg::HDR_W-1:0]  protocol_type;
  logic [arpc_pkg::HDR_W-1:0]  arp_operation;
  logic [arpc_pkg::IP_W-1:0]   ip_address;
  logic [arpc_pkg::MAC_W-1:0]  mac_address;
  logic [arpc_pkg::IP_W-1:0]   target_addr;

  modport source (
    output valid, command, frame_length, hardware_type, protocol_type,
           arp_operation, ip_address, mac_address, target_addr,
    input  ready
  );

  modport sink (
    input  valid, command, frame_length, hardware_type, protocol_type,
           arp_operation, ip_address, mac_address, target_addr,
    output ready
  );
endinterface

`default_nettype wire

>>> sv/arpc_res_if.sv
`default_nettype none

interface arpc_res_if;
  logic                        valid;
  logic                        ready;
  logic                        packet_accepted;
  logic                        resolve_hit;
  logic [arpc_pkg::MAC_W-1:0]  resolved_mac;
  logic                        send_reply;
  logic [arpc_pkg::MAC_W-1:0]  reply_dest_mac;
  logic [arpc_pkg::IP_W-1:0]   reply_dest_ip;

  modport source (
    output valid, packet_accepted, resolve_hit, resolved_mac, send_reply,
           reply_dest_mac, reply_dest_ip,
    input  ready
  );

  modport sink (
    input  valid, packet_accepted, resolve_hit, resolved_mac, send_reply,
           reply_dest_mac, reply_dest_ip,
    output ready
  );
endinterface

`default_nettype wire

>>> sv/arpc_cfg_if.sv
`default_nettype none

interface arpc_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [0:0]                  index;
  logic [arpc_pkg::CFG_W-1:0]  data;

  modport source (
    output valid, index, data,
    input  ready
  );

  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

`default_nettype wire

>>> sv/arp_cache_and_responder_unit.sv
// ARP cache and responder.
// req carries one command per transfer: a parsed received ARP packet, a direct
// learn, a resolve or a timer tick. rsp returns exactly one result per
// command. cfg writes the station IP (index 0) and the station MAC (index 1);
// the station MAC is the reply source address and is kept by the frame
// builder, so here the write is taken and dropped. cfg is always ready.
// A learn or resolve walks the table one entry per cycle through a single
// registered read port and one compare unit. The scan length, set by the one
// table read port, fixes the rate: req is ready only while no command is in
// work. A finished result sits in the rsp output register, so the next
// command is accepted even while rsp is stalled; that command then waits for
// the register to drain before finishing.
// Reset (synchronous, active high) clears all entry valid flags, the tick
// counter, the station IP and rsp valid; the table contents are not cleared.
`default_nettype none

module arp_cache_and_responder_unit #(
  parameter int unsigned CACHE_ENTRIES = arpc_pkg::CACHE_ENTRIES_DEFAULT
) (
  input wire logic  clk,
  input wire logic  rst,
  arpc_cmd_if.sink   req,
  arpc_res_if.source rsp,
  arpc_cfg_if.sink   cfg
);
  import arpc_pkg::*;

  localparam int unsigned IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(CACHE_ENTRIES + 1);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(CACHE_ENTRIES - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(CACHE_ENTRIES);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_RESULT
  } state_t;

  state_t             state;
  logic               is_learn;
  logic [IP_W-1:0]    key_ip;
  logic [MAC_W-1:0]   key_mac;
  logic [CNT_W-1:0]   issue_cnt;
  logic               eval_pend;
  logic [IDX_W-1:0]   eval_idx;
  logic [STAMP_W-1:0] best;
  logic [IDX_W-1:0]   pick;
  result_t            hold;
  result_t            out_res;
  logic               out_valid;
  logic [IP_W-1:0]    own_ip;
  logic [STAMP_W-1:0] tick_counter;

  logic       [IDX_W-1:0] rd_addr;
  logic                   rd_vld;
  entry_t                 rd_entry;
  logic                   we;
  entry_t                 wr_entry;
  logic                   issue_ok;
  logic                   hit_now;
  logic                   older;
  logic                   last;
  logic                   pkt_ok;
  logic                   reply_ok;
  logic                   res_load;
  result_t                start_res;

  // table storage
  arpc_table #(
    .DEPTH (CACHE_ENTRIES),
    .IDX_W (IDX_W)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .rd_addr  (rd_addr),
    .rd_vld   (rd_vld),
    .rd_entry (rd_entry),
    .we       (we),
    .wr_addr  (pick),
    .wr_entry (wr_entry)
  );

  // scan read issue
  assign rd_addr  = issue_cnt[IDX_W-1:0];
  assign issue_ok = (state == ST_SCAN) && (issue_cnt < DEPTH_CNT);

  // shared compare unit on the entry just read
  assign hit_now = rd_vld && (rd_entry.ip == key_ip);
  assign older   = rd_entry.stamp < best;
  assign last    = eval_idx == LAST_IDX;

  // packet checks
  assign pkt_ok   = (req.frame_length >= MIN_ARP_LEN) && (req.hardware_type == HTYPE_ETH)
                    && (req.protocol_type == PTYPE_IPV4);
  assign reply_ok = (req.arp_operation == OPER_REQUEST) && (req.target_addr == own_ip);

  // result fields known at accept
  always_comb begin
    start_res = '0;
    if ((cmd_t'(req.command) == CMD_PACKET) && pkt_ok) begin
      start_res.packet_accepted = 1'b1;
      if (reply_ok) begin
        start_res.send_reply     = 1'b1;
        start_res.reply_dest_mac = req.mac_address;
        start_res.reply_dest_ip  = req.ip_address;
      end
    end
  end

  // entry write
  assign we       = state == ST_WRITE;
  assign wr_entry = '{ip: key_ip, mac: key_mac, stamp: tick_counter};

  // output register takes a finished result when empty or draining
  assign res_load = (state == ST_RESULT) && (!out_valid || rsp.ready);

  // handshakes and result port
  assign req.ready           = state == ST_IDLE;
  assign cfg.ready           = 1'b1;
  assign rsp.valid           = out_valid;
  assign rsp.packet_accepted = out_res.packet_accepted;
  assign rsp.resolve_hit     = out_res.resolve_hit;
  assign rsp.resolved_mac    = out_res.resolved_mac;
  assign rsp.send_reply      = out_res.send_reply;
  assign rsp.reply_dest_mac  = out_res.reply_dest_mac;
  assign rsp.reply_dest_ip   = out_res.reply_dest_ip;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      out_valid    <= 1'b0;
      eval_pend    <= 1'b0;
      own_ip       <= '0;
      tick_counter <= '0;
    end else begin
      // configuration transfer
      if (cfg.valid) begin
        unique case (cfg_reg_t'(cfg.index))
          CFG_OWN_IP:  own_ip <= cfg.data[IP_W-1:0];
          CFG_OWN_MAC: ;
        endcase
      end

      // output register loads or drains
      if (res_load) begin
        out_res   <= hold;
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (req.valid) begin
            key_ip    <= req.ip_address;
            key_mac   <= req.mac_address;
            issue_cnt <= '0;
            eval_pend <= 1'b0;
            best      <= STAMP_MAX;
            pick      <= '0;
            hold      <= start_res;
            unique case (cmd_t'(req.command))
              CMD_PACKET: begin
                is_learn <= 1'b1;
                state    <= pkt_ok ? ST_SCAN : ST_RESULT;
              end
              CMD_LEARN: begin
                is_learn <= 1'b1;
                state    <= ST_SCAN;
              end
              CMD_RESOLVE: begin
                is_learn <= 1'b0;
                state    <= ST_SCAN;
              end
              CMD_TICK: begin
                tick_counter <= tick_counter + STAMP_W'(1);
                state        <= ST_RESULT;
              end
            endcase
          end
        end

        ST_SCAN: begin
          eval_pend <= issue_ok;
          eval_idx  <= rd_addr;
          if (issue_ok) begin
            issue_cnt <= issue_cnt + CNT_W'(1);
          end
          if (eval_pend) begin
            if (is_learn) begin
              // matching entry or first free slot ends the walk
              if (hit_now || !rd_vld) begin
                pick  <= eval_idx;
                state <= ST_WRITE;
              end else begin
                if (older) begin
                  best <= rd_entry.stamp;
                  pick <= eval_idx;
                end
                if (last) begin
                  state <= ST_WRITE;
                end
              end
            end else begin
              if (hit_now) begin
                hold  <= '{packet_accepted: 1'b0, resolve_hit: 1'b1,
                           resolved_mac: rd_entry.mac, send_reply: 1'b0,
                           reply_dest_mac: '0, reply_dest_ip: '0};
                state <= ST_RESULT;
              end else if (last) begin
                state <= ST_RESULT;
              end
            end
          end
        end

        ST_WRITE: begin
          state <= ST_RESULT;
        end

        ST_RESULT: begin
          if (res_load) begin
            state <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> sv/arpc_table.sv
`default_nettype none

module arpc_table #(
  parameter int unsigned DEPTH = arpc_pkg::CACHE_ENTRIES_DEFAULT,
  parameter int unsigned IDX_W = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [IDX_W-1:0] rd_addr,
  output      logic             rd_vld,
  output      arpc_pkg::entry_t rd_entry,
  input  wire logic             we,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire arpc_pkg::entry_t wr_entry
);
  import arpc_pkg::*;

  entry_t           mem [DEPTH];
  logic [DEPTH-1:0] valid_bits;

  // entry storage, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_entry;
    end
    rd_entry <= mem[rd_addr];
  end

  // valid flags, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
      rd_vld     <= 1'b0;
    end else begin
      if (we) begin
        valid_bits[wr_addr] <= 1'b1;
      end
      rd_vld <= valid_bits[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> sim/arp_cache_and_responder_unit_tb.sv
module arp_cache_and_responder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import arpc_pkg::*;

  localparam int unsigned ENTRIES = CACHE_ENTRIES_DEFAULT;
  localparam int unsigned POOL_SIZE = 24;
  localparam int unsigned ITEMS_PER_PHASE = 500;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam longint unsigned CYCLE_LIMIT = 1000000;

  // one command as offered on req
  typedef struct packed {
    cmd_t              command;
    logic [HDR_W-1:0]  frame_length;
    logic [HDR_W-1:0]  hardware_type;
    logic [HDR_W-1:0]  protocol_type;
    logic [HDR_W-1:0]  arp_operation;
    logic [IP_W-1:0]   ip_address;
    logic [MAC_W-1:0]  mac_address;
    logic [IP_W-1:0]   target_addr;
  } arp_cmd_t;

  // mirror of the arp table and the results it predicts
  class arp_scoreboard_t;
    logic [IP_W-1:0]    station_ip;
    logic [MAC_W-1:0]   station_mac;
    bit                 entry_live[ENTRIES];
    entry_t             entries[ENTRIES];
    logic [STAMP_W-1:0] ticks;
    result_t            pending_results[$];
    int                 errors;

    function new();
      station_ip  = '0;
      station_mac = '0;
      ticks       = '0;
      errors      = 0;
      foreach (entry_live[i]) begin
        entry_live[i] = 1'b0;
        entries[i]    = '0;
      end
    endfunction

    function void set_register(cfg_reg_t idx, logic [CFG_W-1:0] value);
      if (idx == CFG_OWN_IP) station_ip = value[IP_W-1:0];
      else station_mac = value[MAC_W-1:0];
    endfunction

    // update a matching entry, else first free slot, else oldest stamp
    function void learn_entry(logic [IP_W-1:0] ip, logic [MAC_W-1:0] mac);
      int                 pick;
      logic [STAMP_W-1:0] oldest;
      pick   = 0;
      oldest = STAMP_MAX;
      for (int i = 0; i < ENTRIES; i++) begin
        if (entry_live[i] && entries[i].ip == ip) begin
          entries[i].mac   = mac;
          entries[i].stamp = ticks;
          return;
        end
        if (!entry_live[i]) begin
          pick = i;
          break;
        end
        if (entries[i].stamp < oldest) begin
          oldest = entries[i].stamp;
          pick   = i;
        end
      end
      entries[pick].ip    = ip;
      entries[pick].mac   = mac;
      entries[pick].stamp = ticks;
      entry_live[pick]    = 1'b1;
    endfunction

    function void note_command(arp_cmd_t c);
      result_t r;
      r = '0;
      case (c.command)
        CMD_PACKET: begin
          if (c.frame_length >= MIN_ARP_LEN && c.hardware_type == HTYPE_ETH &&
              c.protocol_type == PTYPE_IPV4) begin
            r.packet_accepted = 1'b1;
            learn_entry(c.ip_address, c.mac_address);
            if (c.arp_operation == OPER_REQUEST && c.target_addr == station_ip) begin
              r.send_reply     = 1'b1;
              r.reply_dest_mac = c.mac_address;
              r.reply_dest_ip  = c.ip_address;
            end
          end
        end
        CMD_LEARN: learn_entry(c.ip_address, c.mac_address);
        CMD_RESOLVE: begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (entry_live[i] && entries[i].ip == c.ip_address) begin
              r.resolve_hit  = 1'b1;
              r.resolved_mac = entries[i].mac;
              break;
            end
          end
        end
        default: ticks = ticks + STAMP_W'(1);
      endcase
      pending_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none actual %h", $time, got);
        return;
      end
      want = pending_results.pop_front();
      compare_field("packet_accepted", 64'(want.packet_accepted), 64'(got.packet_accepted));
      compare_field("resolve_hit", 64'(want.resolve_hit), 64'(got.resolve_hit));
      compare_field("resolved_mac", 64'(want.resolved_mac), 64'(got.resolved_mac));
      compare_field("send_reply", 64'(want.send_reply), 64'(got.send_reply));
      compare_field("reply_dest_mac", 64'(want.reply_dest_mac), 64'(got.reply_dest_mac));
      compare_field("reply_dest_ip", 64'(want.reply_dest_ip), 64'(got.reply_dest_ip));
    endfunction
  endclass

  logic clk;
  logic rst;

  arpc_cmd_if req_if ();
  arpc_res_if rsp_if ();
  arpc_cfg_if cfg_if ();

  arp_cache_and_responder_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if),
    .cfg (cfg_if)
  );

  arp_scoreboard_t sb = new();

  int unsigned     sender_idle_pct;
  int unsigned     receiver_stall_pct;
  int unsigned     hold_left;
  longint unsigned cycle_count;
  logic [IP_W-1:0] station_ip;
  logic [IP_W-1:0] ip_pool[POOL_SIZE];

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) @(posedge clk) cycle_count++;
    $display("arp_cache_and_responder_unit verification failed");
    $finish;
  end

  // receiver ready, with an optional long hold-off
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  // check every result transfer
  always @(posedge clk) begin : result_monitor
    result_t got;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      got.packet_accepted = rsp_if.packet_accepted;
      got.resolve_hit     = rsp_if.resolve_hit;
      got.resolved_mac    = rsp_if.resolved_mac;
      got.send_reply      = rsp_if.send_reply;
      got.reply_dest_mac  = rsp_if.reply_dest_mac;
      got.reply_dest_ip   = rsp_if.reply_dest_ip;
      sb.check_result(got);
    end
  end

  function automatic logic [MAC_W-1:0] rand_mac();
    logic [63:0] w;
    int unsigned roll;
    w    = {$urandom, $urandom};
    roll = $urandom_range(99);
    if (roll < 5) return '0;
    if (roll < 10) return '1;
    return w[MAC_W-1:0];
  endfunction

  // mostly addresses from a small pool so hits and evictions happen
  function automatic logic [IP_W-1:0] pick_ip();
    if ($urandom_range(99) < 85) return ip_pool[$urandom_range(POOL_SIZE - 1)];
    return $urandom;
  endfunction

  function automatic arp_cmd_t make_item(cmd_t cmd, logic [HDR_W-1:0] len,
                                         logic [HDR_W-1:0] htype, logic [HDR_W-1:0] ptype,
                                         logic [HDR_W-1:0] oper, logic [IP_W-1:0] ip,
                                         logic [MAC_W-1:0] mac, logic [IP_W-1:0] tip);
    arp_cmd_t c;
    c.command       = cmd;
    c.frame_length  = len;
    c.hardware_type = htype;
    c.protocol_type = ptype;
    c.arp_operation = oper;
    c.ip_address    = ip;
    c.mac_address   = mac;
    c.target_addr   = tip;
    return c;
  endfunction

  function automatic arp_cmd_t make_random_command();
    arp_cmd_t    c;
    int unsigned roll;
    // fields a command ignores carry noise
    c.frame_length  = 16'($urandom);
    c.hardware_type = 16'($urandom);
    c.protocol_type = 16'($urandom);
    c.arp_operation = 16'($urandom);
    c.ip_address    = pick_ip();
    c.mac_address   = rand_mac();
    c.target_addr   = $urandom;
    roll = $urandom_range(99);
    if (roll < 35) begin
      c.command = CMD_PACKET;
      roll = $urandom_range(99);
      if (roll < 90) begin
        // well-formed header, a few broken in exactly one place
        c.frame_length  = ($urandom_range(9) == 0) ?
                          16'($urandom_range(65535, MIN_ARP_LEN)) :
                          16'($urandom_range(64, MIN_ARP_LEN));
        c.hardware_type = HTYPE_ETH;
        c.protocol_type = PTYPE_IPV4;
        if (roll >= 80) begin
          case ($urandom_range(2))
            0: c.frame_length = 16'($urandom_range(MIN_ARP_LEN - 1));
            1: c.hardware_type = HTYPE_ETH ^ (16'h1 << $urandom_range(15));
            default: c.protocol_type = PTYPE_IPV4 ^ (16'h1 << $urandom_range(15));
          endcase
        end
      end
      roll = $urandom_range(99);
      if (roll < 60) c.arp_operation = OPER_REQUEST;
      else if (roll < 85) c.arp_operation = 16'h0002;
      c.target_addr = ($urandom_range(1) == 0) ? station_ip : pick_ip();
    end else if (roll < 55) begin
      c.command = CMD_LEARN;
    end else if (roll < 80) begin
      c.command = CMD_RESOLVE;
    end else begin
      c.command = CMD_TICK;
    end
    return c;
  endfunction

  // offer one command, with random idle cycles ahead of it
  task automatic send_command(arp_cmd_t c);
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk);
      req_if.valid = 1'b0;
    end
    @(negedge clk);
    req_if.valid         = 1'b1;
    req_if.command       = c.command;
    req_if.frame_length  = c.frame_length;
    req_if.hardware_type = c.hardware_type;
    req_if.protocol_type = c.protocol_type;
    req_if.arp_operation = c.arp_operation;
    req_if.ip_address    = c.ip_address;
    req_if.mac_address   = c.mac_address;
    req_if.target_addr   = c.target_addr;
    do @(posedge clk); while (!req_if.ready);
    sb.note_command(c);
  endtask

  task automatic write_register(cfg_reg_t idx, logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = value;
    do @(posedge clk); while (!cfg_if.ready);
    sb.set_register(idx, value);
    if (idx == CFG_OWN_IP) station_ip = value[IP_W-1:0];
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // stop offering and wait for every expected result
  task automatic drain_results();
    @(negedge clk);
    req_if.valid = 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
  endtask

  initial begin : main_sequence
    logic [IP_W-1:0]  ip_a;
    logic [IP_W-1:0]  ip_b;
    logic [MAC_W-1:0] mac_a;
    ip_a = 32'hC0A8_0102;
    ip_b = 32'h0A00_00FE;
    mac_a = 48'h0200_1122_3344;

    // all inputs known from time zero
    rst                  = 1'b1;
    req_if.valid         = 1'b0;
    req_if.command       = CMD_PACKET;
    req_if.frame_length  = '0;
    req_if.hardware_type = '0;
    req_if.protocol_type = '0;
    req_if.arp_operation = '0;
    req_if.ip_address    = '0;
    req_if.mac_address   = '0;
    req_if.target_addr   = '0;
    cfg_if.valid         = 1'b0;
    cfg_if.index         = CFG_OWN_IP;
    cfg_if.data          = '0;
    sender_idle_pct      = 0;
    receiver_stall_pct   = 0;
    hold_left            = 0;
    station_ip           = '0;

    ip_pool[0] = '0;
    ip_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) ip_pool[i] = $urandom;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed commands at reset configuration (station ip zero)
    send_command(make_item(CMD_RESOLVE, '1, '1, '1, '1, '0, '1, '1));
    send_command(make_item(CMD_TICK, '1, '1, '1, '1, '1, '1, '1));
    // too short by one byte, then empty
    send_command(make_item(CMD_PACKET, 16'd27, HTYPE_ETH, PTYPE_IPV4, OPER_REQUEST,
                           ip_a, mac_a, '0));
    send_command(make_item(CMD_PACKET, 16'd0, HTYPE_ETH, PTYPE_IPV4, OPER_REQUEST,
                           ip_a, mac_a, '0));
    // shortest valid request for the station address
    send_command(make_item(CMD_PACKET, MIN_ARP_LEN, HTYPE_ETH, PTYPE_IPV4, OPER_REQUEST,
                           ip_a, mac_a, '0));
    // wrong hardware or protocol type
    send_command(make_item(CMD_PACKET, '1, 16'h0000, PTYPE_IPV4, OPER_REQUEST,
                           ip_b, mac_a, '0));
    send_command(make_item(CMD_PACKET, '1, '1, PTYPE_IPV4, OPER_REQUEST, ip_b, mac_a, '0));
    send_command(make_item(CMD_PACKET, '1, HTYPE_ETH, 16'h0801, OPER_REQUEST,
                           ip_b, mac_a, '0));
    send_command(make_item(CMD_PACKET, '1, HTYPE_ETH, '1, OPER_REQUEST, ip_b, mac_a, '0));
    // non-request operations are learned but not answered
    send_command(make_item(CMD_PACKET, '1, HTYPE_ETH, PTYPE_IPV4, 16'h0002,
                           ip_b, 48'h0A0B_0C0D_0E0F, '0));
    send_command(make_item(CMD_PACKET, 16'd100, HTYPE_ETH, PTYPE_IPV4, 16'h0000,
                           32'h7F00_0001, 48'h1, '0));
    send_command(make_item(CMD_PACKET, 16'd60, HTYPE_ETH, PTYPE_IPV4, '1,
                           32'hAC10_0001, '1, '0));
    // request for some other station
    send_command(make_item(CMD_PACKET, 16'd28, HTYPE_ETH, PTYPE_IPV4, OPER_REQUEST,
                           '0, '0, '1));
    send_command(make_item(CMD_LEARN, '0, '0, '0, '0, '1, '1, '0));
    send_command(make_item(CMD_TICK, '0, '0, '0, '0, '0, '0, '0));
    // refresh an existing entry with a new mac
    send_command(make_item(CMD_LEARN, '1, '1, '1, '1, ip_a, 48'hFEED_0000_BEEF, '1));
    send_command(make_item(CMD_RESOLVE, '0, '0, '0, '0, ip_a, '1, '0));
    send_command(make_item(CMD_RESOLVE, '0, '0, '0, '0, '1, '0, '0));
    send_command(make_item(CMD_RESOLVE, '0, '0, '0, '0, '0, '0, '0));
    send_command(make_item(CMD_RESOLVE, '1, '1, '1, '1, 32'h0102_0304, '1, '1));
    // a rejected sender must not be learned
    send_command(make_item(CMD_PACKET, 16'd27, HTYPE_ETH, PTYPE_IPV4, 16'h0002,
                           32'h0505_0505, mac_a, '0));
    send_command(make_item(CMD_RESOLVE, '0, '0, '0, '0, 32'h0505_0505, '0, '0));
    send_command(make_item(CMD_TICK, '1, '0, '1, '0, '1, '0, '1));

    // random phases, each with its own configuration and idling
    for (int phase = 0; phase < 4; phase++) begin
      drain_results();
      case (phase)
        0: begin
          write_register(CFG_OWN_IP, {16'h0, 32'hFFFF_FFFF});
          write_register(CFG_OWN_MAC, '1);
        end
        1: begin
          write_register(CFG_OWN_IP, {16'h0, ip_pool[$urandom_range(POOL_SIZE - 1)]});
          write_register(CFG_OWN_MAC, '0);
        end
        2: begin
          write_register(CFG_OWN_IP, '0);
          write_register(CFG_OWN_MAC, rand_mac());
        end
        default: begin
          write_register(CFG_OWN_IP, {16'h0, 32'($urandom)});
          write_register(CFG_OWN_MAC, rand_mac());
        end
      endcase
      case (phase)
        0: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
          hold_left          = HOLD_CYCLES;
        end
        1: begin
          sender_idle_pct    = 64;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 64;
        end
        default: begin
          sender_idle_pct    = 31;
          receiver_stall_pct = 31;
        end
      endcase
      repeat (ITEMS_PER_PHASE) send_command(make_random_command());
    end

    // let the block settle after the last result
    drain_results();
    repeat (ENTRIES + 8) @(posedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("arp_cache_and_responder_unit verification clean");
    end else begin
      $display("arp_cache_and_responder_unit verification failed");
    end
    $finish;
  end

endmodule
